>>> design/kdp_pkg.sv
// Shared types, constants and helper functions for the key debounce and page refresh policy unit.
package kdp_pkg;

  // Field widths fixed by the port format.
  localparam int PORT_W     = 6;
  localparam int KEYS_W     = 5;
  localparam int TIME_W     = 32;
  localparam int DEB_W      = 16;
  localparam int LIMIT_W    = 8;
  localparam int TABLE_W    = 10;
  localparam int PAGE_W     = 3;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Number of sample bits that are keys; the other key-field bits only cause status refreshes.
  localparam int KEY_COUNT  = 5;
  localparam int CARD_BIT   = 5;
  localparam int PAGE_COUNT = 5;

  localparam logic [KEYS_W-1:0] KEY_MASK =
    (KEY_COUNT >= KEYS_W) ? {KEYS_W{1'b1}} : KEYS_W'((1 << KEY_COUNT) - 1);

  // Reset values.
  localparam logic [PORT_W-1:0]   PORT_IDLE    = {PORT_W{1'b1}};
  localparam logic [DEB_W-1:0]    DEBOUNCE_RST = DEB_W'(20);
  localparam logic [LIMIT_W-1:0]  LIMIT_RST    = LIMIT_W'(6);
  localparam logic [TABLE_W-1:0]  TABLE_RST    = TABLE_W'(585);

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_FULL   = 2'd1,
    ACT_STATUS = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    MODE_QUALITY = 2'd0,
    MODE_TEXT    = 2'd1,
    MODE_FAST    = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_DEBOUNCE = 2'd1,
    CFG_BURST    = 2'd2,
    CFG_TABLE    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic               enable;
    logic [DEB_W-1:0]   debounce_ms;
    logic [LIMIT_W-1:0] fast_burst_limit;
    logic [TABLE_W-1:0] page_mode_table;
  } cfg_t;

  typedef struct packed {
    logic                kind;
    logic [PORT_W-1:0]   port_sample;
    logic [TIME_W-1:0]   now_ms;
    logic                irq_level_low;
  } in_beat_t;

  typedef struct packed {
    action_t            action;
    mode_t              draw_mode;
    logic [PAGE_W-1:0]  page;
    logic [KEYS_W-1:0]  keys_down;
    logic               card_present;
    logic               irq_low;
    logic [CNT_W-1:0]   full_count;
    logic [CNT_W-1:0]   partial_count;
  } res_t;

  // Index of the lowest set bit; only called with a nonzero vector.
  function automatic logic [PAGE_W-1:0] lowest_key(input logic [KEYS_W-1:0] pressed);
    logic [PAGE_W-1:0] k;
    k = PAGE_W'(KEYS_W);
    for (int i = KEYS_W - 1; i >= 0; i--) begin
      if (pressed[i]) begin
        k = PAGE_W'(i);
      end
    end
    return k;
  endfunction

  // Table lookup: pages without an entry and codes two and three all read as fast.
  function automatic mode_t table_mode(input logic [TABLE_W-1:0] tbl,
                                       input logic [PAGE_W-1:0] page);
    logic [1:0] code;
    code = 2'(MODE_FAST);
    for (int p = 0; p < PAGE_COUNT; p++) begin
      if (page == PAGE_W'(p)) begin
        code = tbl[2*p +: 2];
      end
    end
    return code[1] ? MODE_FAST : mode_t'(code);
  endfunction

endpackage

>>> design/kdp_if.sv
// Valid/ready channel interfaces for poll beats and result beats.
interface kdp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [kdp_pkg::PORT_W-1:0]    port_sample;
  logic [kdp_pkg::TIME_W-1:0]    now_ms;
  logic                          irq_level_low;

  modport source (output valid, kind, port_sample, now_ms, irq_level_low, input ready);
  modport sink   (input valid, kind, port_sample, now_ms, irq_level_low, output ready);
endinterface

interface kdp_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [1:0]                  draw_mode;
  logic [kdp_pkg::PAGE_W-1:0]  page;
  logic [kdp_pkg::KEYS_W-1:0]  keys_down;
  logic                        card_present;
  logic                        irq_low;
  logic [kdp_pkg::CNT_W-1:0]   full_count;
  logic [kdp_pkg::CNT_W-1:0]   partial_count;

  modport source (output valid, action, draw_mode, page, keys_down, card_present,
                  irq_low, full_count, partial_count, input ready);
  modport sink   (input valid, action, draw_mode, page, keys_down, card_present,
                  irq_low, full_count, partial_count, output ready);
endinterface

>>> design/kdp_cfg.sv
// Configuration register file with a plain write port.
module kdp_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [kdp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kdp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output kdp_pkg::cfg_t                    cfg
);

  kdp_pkg::cfg_t cfg_r;
  kdp_pkg::cfg_t cfg_nxt;

  // Decode the register index and update the addressed field.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        kdp_pkg::CFG_ENABLE:   cfg_nxt.enable = cfg_wdata[0];
        kdp_pkg::CFG_DEBOUNCE: cfg_nxt.debounce_ms = cfg_wdata[kdp_pkg::DEB_W-1:0];
        kdp_pkg::CFG_BURST:    cfg_nxt.fast_burst_limit = cfg_wdata[kdp_pkg::LIMIT_W-1:0];
        kdp_pkg::CFG_TABLE:    cfg_nxt.page_mode_table = cfg_wdata[kdp_pkg::TABLE_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable           <= 1'b1;
      cfg_r.debounce_ms      <= kdp_pkg::DEBOUNCE_RST;
      cfg_r.fast_burst_limit <= kdp_pkg::LIMIT_RST;
      cfg_r.page_mode_table  <= kdp_pkg::TABLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/kdp_in_stage.sv
// Input register that holds one poll beat until the policy stage takes it.
module kdp_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  kdp_pkg::in_beat_t    in_data,
  input  logic                 advance,
  output logic                 hold_valid,
  output kdp_pkg::in_beat_t    hold_data
);

  logic              valid_r;
  logic              valid_nxt;
  kdp_pkg::in_beat_t data_r;

  // The register may refill whenever it is empty or its beat moves on this cycle.
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign hold_valid = valid_r;
  assign hold_data  = data_r;

endmodule

>>> design/kdp_policy.sv
// Debounce state, refresh policy and the registered result beat.
module kdp_policy (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kdp_pkg::cfg_t        cfg,
  input  logic                 item_valid,
  input  kdp_pkg::in_beat_t    item,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_ready,
  output kdp_pkg::res_t        res
);

  logic [kdp_pkg::PORT_W-1:0]   last_sample_r, last_sample_nxt;
  logic [kdp_pkg::TIME_W-1:0]   change_time_r, change_time_nxt;
  logic [kdp_pkg::PORT_W-1:0]   accepted_port_r, accepted_port_nxt;
  logic                         accepted_irq_r, accepted_irq_nxt;
  logic [kdp_pkg::PAGE_W-1:0]   page_r, page_nxt;
  logic [kdp_pkg::LIMIT_W-1:0]  fast_streak_r, fast_streak_nxt;
  logic [kdp_pkg::CNT_W-1:0]    full_r, full_nxt;
  logic [kdp_pkg::CNT_W-1:0]    partial_r, partial_nxt;
  logic                         out_valid_r, out_valid_nxt;
  kdp_pkg::res_t                res_r, res_nxt;

  logic                         fire;
  logic [kdp_pkg::TIME_W-1:0]   elapsed;
  logic [kdp_pkg::KEYS_W-1:0]   pressed;
  logic                         do_full;
  logic                         pin_quality;
  kdp_pkg::action_t             action;
  kdp_pkg::mode_t               mode;

  // A beat moves into the result register when that register is free or being emptied.
  assign advance = !out_valid_r || out_ready;
  assign fire    = item_valid && advance;

  // Wrapping time since the last sample change, and keys that are down now but were up.
  assign elapsed = item.now_ms - change_time_r;
  assign pressed = ~item.port_sample[kdp_pkg::KEYS_W-1:0]
                   & accepted_port_r[kdp_pkg::KEYS_W-1:0] & kdp_pkg::KEY_MASK;

  // Debounce and acceptance decision for one poll.
  always_comb begin
    last_sample_nxt   = last_sample_r;
    change_time_nxt   = change_time_r;
    accepted_port_nxt = accepted_port_r;
    accepted_irq_nxt  = accepted_irq_r;
    page_nxt          = page_r;
    fast_streak_nxt   = fast_streak_r;
    full_nxt          = full_r;
    partial_nxt       = partial_r;
    action            = kdp_pkg::ACT_NONE;
    mode              = kdp_pkg::MODE_QUALITY;
    do_full           = 1'b0;
    pin_quality       = 1'b0;

    if (fire && cfg.enable) begin
      if (item.kind) begin
        last_sample_nxt   = item.port_sample;
        accepted_port_nxt = item.port_sample;
        accepted_irq_nxt  = item.irq_level_low;
        do_full           = 1'b1;
        pin_quality       = 1'b1;
      end else if (item.port_sample != last_sample_r) begin
        last_sample_nxt = item.port_sample;
        change_time_nxt = item.now_ms;
      end else if (item.port_sample != accepted_port_r &&
                   elapsed >= kdp_pkg::TIME_W'(cfg.debounce_ms)) begin
        accepted_port_nxt = item.port_sample;
        accepted_irq_nxt  = item.irq_level_low;
        if (|pressed) begin
          page_nxt = kdp_pkg::lowest_key(pressed);
          do_full  = 1'b1;
        end else begin
          partial_nxt = partial_r + kdp_pkg::CNT_W'(1);
          action      = kdp_pkg::ACT_STATUS;
          mode        = kdp_pkg::MODE_FAST;
        end
      end
    end

    // Full refresh: table mode, forced to quality by a start or a long streak of non-quality modes.
    if (do_full) begin
      action   = kdp_pkg::ACT_FULL;
      full_nxt = full_r + kdp_pkg::CNT_W'(1);
      mode     = kdp_pkg::table_mode(cfg.page_mode_table, page_nxt);
      if (pin_quality || fast_streak_r >= cfg.fast_burst_limit) begin
        mode = kdp_pkg::MODE_QUALITY;
      end
      if (mode == kdp_pkg::MODE_QUALITY) begin
        fast_streak_nxt = '0;
      end else begin
        fast_streak_nxt = fast_streak_r + kdp_pkg::LIMIT_W'(1);
      end
    end
  end

  // Result beat as seen after this poll.
  always_comb begin
    res_nxt.action        = action;
    res_nxt.draw_mode     = mode;
    res_nxt.page          = page_nxt;
    res_nxt.keys_down     = ~accepted_port_nxt[kdp_pkg::KEYS_W-1:0] & kdp_pkg::KEY_MASK;
    res_nxt.card_present  = ~accepted_port_nxt[kdp_pkg::CARD_BIT];
    res_nxt.irq_low       = accepted_irq_nxt;
    res_nxt.full_count    = full_nxt;
    res_nxt.partial_count = partial_nxt;
  end

  // Result valid: set by a moving beat, cleared when the sink takes it.
  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r   <= kdp_pkg::PORT_IDLE;
      change_time_r   <= '0;
      accepted_port_r <= kdp_pkg::PORT_IDLE;
      accepted_irq_r  <= 1'b0;
      page_r          <= '0;
      fast_streak_r   <= '0;
      full_r          <= '0;
      partial_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      last_sample_r   <= last_sample_nxt;
      change_time_r   <= change_time_nxt;
      accepted_port_r <= accepted_port_nxt;
      accepted_irq_r  <= accepted_irq_nxt;
      page_r          <= page_nxt;
      fast_streak_r   <= fast_streak_nxt;
      full_r          <= full_nxt;
      partial_r       <= partial_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

>>> design/key_debounce_page_refresh_policy_unit.sv
// Top level: key debounce and page refresh policy unit.
// A held poll moves into the result register when that register is free or emptied.
// Throughput: one poll per cycle unless a result waits; the input may then stall.
// The whole policy step is one pass of logic between the input and result registers.
// Reset (rst_n low, synchronous) empties both registers, restores the debounce state
// and the configuration defaults; no clearing pass is needed.
module key_debounce_page_refresh_policy_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [kdp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kdp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  kdp_in_if.sink                           in_ch,
  kdp_out_if.source                        out_ch
);

  kdp_pkg::cfg_t     cfg;
  kdp_pkg::in_beat_t in_data;
  kdp_pkg::in_beat_t hold_data;
  kdp_pkg::res_t     res;
  logic              hold_valid;
  logic              advance;

  // Gather the input beat fields.
  assign in_data.kind          = in_ch.kind;
  assign in_data.port_sample   = in_ch.port_sample;
  assign in_data.now_ms        = in_ch.now_ms;
  assign in_data.irq_level_low = in_ch.irq_level_low;

  kdp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kdp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_data    (in_data),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  kdp_policy u_policy (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (hold_valid),
    .item       (hold_data),
    .advance    (advance),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .res        (res)
  );

  // Spread the result beat onto the output channel.
  assign out_ch.action        = res.action;
  assign out_ch.draw_mode     = res.draw_mode;
  assign out_ch.page          = res.page;
  assign out_ch.keys_down     = res.keys_down;
  assign out_ch.card_present  = res.card_present;
  assign out_ch.irq_low       = res.irq_low;
  assign out_ch.full_count    = res.full_count;
  assign out_ch.partial_count = res.partial_count;

endmodule

>>> design/kdp_checker.sv
// Port-level checker for the policy unit and its bind statement.
module kdp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_action,
  input logic [kdp_pkg::CNT_W-1:0]   out_full_count
);

  logic                       seen_r;
  logic [kdp_pkg::CNT_W-1:0]  last_full_r;

  // Remember the full refresh count of the last delivered result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      last_full_r <= '0;
    end else if (out_valid && out_ready) begin
      seen_r      <= 1'b1;
      last_full_r <= out_full_count;
    end
  end

  // No result beat appears in the cycle after reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  // The input side only stalls while a result beat waits.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (in_valid && !in_ready) |-> (out_valid && !out_ready))
    else $error("input stalled without a waiting result beat");

  // A waiting result beat stays valid.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped before it was taken");

  // Each full refresh advances the count by exactly one from the previous beat.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && out_ready && seen_r &&
                    out_action == 2'(kdp_pkg::ACT_FULL))
                   |-> (out_full_count == last_full_r + kdp_pkg::CNT_W'(1)))
    else $error("full refresh count did not step by one");

  // Beats without a full refresh leave the count unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && out_ready && seen_r &&
                    out_action != 2'(kdp_pkg::ACT_FULL))
                   |-> (out_full_count == last_full_r))
    else $error("full refresh count changed without a full refresh");

endmodule

bind key_debounce_page_refresh_policy_unit kdp_checker u_kdp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_action     (out_ch.action),
  .out_full_count (out_ch.full_count)
);

>>> tb/sv/tb_top.sv
// Testbench for the key debounce and page refresh policy unit: scoreboard against a local policy predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_POLL  = 1'b0;
  localparam logic KIND_START = 1'b1;
  localparam int   GAP_MAX    = 17;
  localparam int   CYCLE_LIMIT = 500000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [kdp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [kdp_pkg::CFG_DATA_W-1:0] cfg_wdata;

  kdp_in_if  in_bus ();
  kdp_out_if out_bus ();

  key_debounce_page_refresh_policy_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  // Predicted policy state and the register settings it runs under.
  kdp_pkg::cfg_t                cfg_model;
  logic [kdp_pkg::PORT_W-1:0]   p_last;
  logic [kdp_pkg::PORT_W-1:0]   p_accepted;
  logic [kdp_pkg::TIME_W-1:0]   p_change_time;
  logic                         p_irq;
  logic [kdp_pkg::PAGE_W-1:0]   p_page;
  logic [kdp_pkg::LIMIT_W-1:0]  p_streak;
  logic [kdp_pkg::CNT_W-1:0]    p_full;
  logic [kdp_pkg::CNT_W-1:0]    p_partial;

  // Refresh reports predicted but not yet seen on the result channel.
  kdp_pkg::res_t reports_due[$];

  int mismatch_count = 0;
  int items_sent = 0;
  int send_gap_max = 0;
  int recv_stall_max = 0;
  int stall_left = 0;
  int hold_cycles = 0;
  logic [kdp_pkg::TIME_W-1:0] clock_ms = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run-away guard.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top NOT OK");
    $finish;
  end

  // Mode looked up for a page; no entry or code two or three means fast.
  function automatic kdp_pkg::mode_t page_mode(input logic [kdp_pkg::PAGE_W-1:0] pg);
    logic [1:0] code;
    if (pg >= kdp_pkg::PAGE_W'(kdp_pkg::PAGE_COUNT)) begin
      return kdp_pkg::MODE_FAST;
    end
    code = cfg_model.page_mode_table[2*pg +: 2];
    if (code >= 2'd2) begin
      return kdp_pkg::MODE_FAST;
    end
    return (code == 2'd1) ? kdp_pkg::MODE_TEXT : kdp_pkg::MODE_QUALITY;
  endfunction

  // Counts a full refresh and applies the burst limit on non-quality modes.
  function automatic kdp_pkg::mode_t issue_full(input logic pin_quality);
    kdp_pkg::mode_t m;
    m = page_mode(p_page);
    p_full = p_full + 1'b1;
    if (pin_quality || p_streak >= cfg_model.fast_burst_limit) begin
      m = kdp_pkg::MODE_QUALITY;
    end
    if (m == kdp_pkg::MODE_QUALITY) begin
      p_streak = '0;
    end else begin
      p_streak = p_streak + 1'b1;
    end
    return m;
  endfunction

  // One poll through the debounce and refresh policy.
  function automatic kdp_pkg::res_t predict_poll(input kdp_pkg::in_beat_t b);
    kdp_pkg::res_t r;
    logic [kdp_pkg::KEYS_W-1:0] was_down;
    logic [kdp_pkg::KEYS_W-1:0] now_down;
    logic [kdp_pkg::KEYS_W-1:0] pressed;
    r.action = kdp_pkg::ACT_NONE;
    r.draw_mode = kdp_pkg::MODE_QUALITY;
    if (cfg_model.enable) begin
      if (b.kind == KIND_START) begin
        p_last = b.port_sample;
        p_accepted = b.port_sample;
        p_irq = b.irq_level_low;
        r.action = kdp_pkg::ACT_FULL;
        r.draw_mode = issue_full(1'b1);
      end else if (b.port_sample != p_last) begin
        p_last = b.port_sample;
        p_change_time = b.now_ms;
      end else if (b.port_sample != p_accepted &&
                   (b.now_ms - p_change_time) >= cfg_model.debounce_ms) begin
        was_down = ~p_accepted[kdp_pkg::KEYS_W-1:0] & kdp_pkg::KEY_MASK;
        now_down = ~b.port_sample[kdp_pkg::KEYS_W-1:0] & kdp_pkg::KEY_MASK;
        pressed = now_down & ~was_down;
        p_accepted = b.port_sample;
        p_irq = b.irq_level_low;
        if (pressed != '0) begin
          for (int k = kdp_pkg::KEYS_W - 1; k >= 0; k--) begin
            if (pressed[k]) begin
              p_page = kdp_pkg::PAGE_W'(k);
            end
          end
          r.action = kdp_pkg::ACT_FULL;
          r.draw_mode = issue_full(1'b0);
        end else begin
          p_partial = p_partial + 1'b1;
          r.action = kdp_pkg::ACT_STATUS;
          r.draw_mode = kdp_pkg::MODE_FAST;
        end
      end
    end
    r.page = p_page;
    r.keys_down = ~p_accepted[kdp_pkg::KEYS_W-1:0] & kdp_pkg::KEY_MASK;
    r.card_present = ~p_accepted[kdp_pkg::CARD_BIT];
    r.irq_low = p_irq;
    r.full_count = p_full;
    r.partial_count = p_partial;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result beat checker; also draws the receiver's stall before the next beat.
  always @(posedge clk) begin
    kdp_pkg::res_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      stall_left = (recv_stall_max == 0) ? 0 : $urandom_range(0, recv_stall_max);
      if (reports_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual action %0h page %0h",
                 $time, out_bus.action, out_bus.page);
        mismatch_count++;
      end else begin
        want = reports_due.pop_front();
        check_field("action", 32'(want.action), 32'(out_bus.action));
        check_field("draw_mode", 32'(want.draw_mode), 32'(out_bus.draw_mode));
        check_field("page", 32'(want.page), 32'(out_bus.page));
        check_field("keys_down", 32'(want.keys_down), 32'(out_bus.keys_down));
        check_field("card_present", 32'(want.card_present), 32'(out_bus.card_present));
        check_field("irq_low", 32'(want.irq_low), 32'(out_bus.irq_low));
        check_field("full_count", want.full_count, out_bus.full_count);
        check_field("partial_count", want.partial_count, out_bus.partial_count);
      end
    end
  end

  // Receiver: long hold-offs first, then the per-beat stall, else ready.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_bus.ready = 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_bus.ready = 1'b0;
        stall_left--;
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  // Offers one poll beat after a random gap and records its predicted report.
  task automatic send_poll(input logic kind, input logic [kdp_pkg::PORT_W-1:0] sample,
                           input logic [kdp_pkg::TIME_W-1:0] stamp, input logic irq);
    kdp_pkg::in_beat_t b;
    int gap;
    b.kind = kind;
    b.port_sample = sample;
    b.now_ms = stamp;
    b.irq_level_low = irq;
    gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.kind = kind;
    in_bus.port_sample = sample;
    in_bus.now_ms = stamp;
    in_bus.irq_level_low = irq;
    in_bus.valid = 1'b1;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    reports_due.push_back(predict_poll(b));
    items_sent++;
  endtask

  // Stops offering beats and waits until every predicted report has arrived.
  task automatic drain_reports();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input kdp_pkg::cfg_idx_t idx,
                           input logic [kdp_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      kdp_pkg::CFG_ENABLE:   cfg_model.enable = val[0];
      kdp_pkg::CFG_DEBOUNCE: cfg_model.debounce_ms = val[kdp_pkg::DEB_W-1:0];
      kdp_pkg::CFG_BURST:    cfg_model.fast_burst_limit = val[kdp_pkg::LIMIT_W-1:0];
      kdp_pkg::CFG_TABLE:    cfg_model.page_mode_table = val[kdp_pkg::TABLE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic en, input logic [kdp_pkg::DEB_W-1:0] deb,
                           input logic [kdp_pkg::LIMIT_W-1:0] lim,
                           input logic [kdp_pkg::TABLE_W-1:0] tbl);
    write_reg(kdp_pkg::CFG_ENABLE, kdp_pkg::CFG_DATA_W'(en));
    write_reg(kdp_pkg::CFG_DEBOUNCE, kdp_pkg::CFG_DATA_W'(deb));
    write_reg(kdp_pkg::CFG_BURST, kdp_pkg::CFG_DATA_W'(lim));
    write_reg(kdp_pkg::CFG_TABLE, kdp_pkg::CFG_DATA_W'(tbl));
  endtask

  // Next sample to settle on, mostly plausible key and card activity.
  function automatic logic [kdp_pkg::PORT_W-1:0] next_target();
    logic [kdp_pkg::PORT_W-1:0] s;
    int pick;
    s = p_accepted;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      s[$urandom_range(0, kdp_pkg::KEYS_W - 1)] = 1'b0;
    end else if (pick < 7) begin
      s[kdp_pkg::KEYS_W-1:0] = '1;
    end else if (pick < 8) begin
      s[kdp_pkg::CARD_BIT] = ~s[kdp_pkg::CARD_BIT];
    end else begin
      s = kdp_pkg::PORT_W'($urandom_range(0, 63));
    end
    return s;
  endfunction

  // A change followed by repeats until, usually, the debounce time has passed.
  task automatic debounce_sequence(input logic [kdp_pkg::PORT_W-1:0] target);
    logic [kdp_pkg::TIME_W-1:0] began;
    int repeats;
    clock_ms = clock_ms + $urandom_range(1, 60);
    began = clock_ms;
    send_poll(KIND_POLL, target, clock_ms, 1'($urandom_range(0, 1)));
    repeats = $urandom_range(1, 4);
    repeat (repeats) begin
      clock_ms = clock_ms + $urandom_range(0, cfg_model.debounce_ms * 3 / 4 + 1);
      send_poll(KIND_POLL, target, clock_ms, 1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 3) != 0 && (clock_ms - began) < cfg_model.debounce_ms) begin
      clock_ms = began + cfg_model.debounce_ms;
      send_poll(KIND_POLL, target, clock_ms, 1'($urandom_range(0, 1)));
    end
  endtask

  // Arbitrary beat: any sample, any stamp, occasionally a start.
  task automatic random_noise();
    logic kind;
    logic [kdp_pkg::TIME_W-1:0] stamp;
    kind = ($urandom_range(0, 7) == 0) ? KIND_START : KIND_POLL;
    stamp = ($urandom_range(0, 1) == 0) ? $urandom() : clock_ms;
    send_poll(kind, kdp_pkg::PORT_W'($urandom_range(0, 63)), stamp,
              1'($urandom_range(0, 1)));
  endtask

  task automatic press_and_release(input int key);
    logic [kdp_pkg::PORT_W-1:0] s;
    s = p_accepted;
    s[kdp_pkg::KEYS_W-1:0] = '1;
    s[key] = 1'b0;
    debounce_sequence(s);
    s[kdp_pkg::KEYS_W-1:0] = '1;
    debounce_sequence(s);
  endtask

  // Reset settings: start, presses, release, card, wrap, glitch, debounce edge.
  task automatic test_directed_basics();
    send_gap_max = 3;
    recv_stall_max = 3;
    send_poll(KIND_START, 6'h3F, 32'd0, 1'b1);
    send_poll(KIND_POLL, 6'h3E, 32'd100, 1'b0);
    send_poll(KIND_POLL, 6'h3E, 32'd119, 1'b1);
    send_poll(KIND_POLL, 6'h3E, 32'd120, 1'b1);
    send_poll(KIND_POLL, 6'h2E, 32'd200, 1'b0);
    send_poll(KIND_POLL, 6'h2E, 32'd220, 1'b0);
    send_poll(KIND_POLL, 6'h3F, 32'd300, 1'b1);
    send_poll(KIND_POLL, 6'h3F, 32'd320, 1'b0);
    send_poll(KIND_POLL, 6'h1F, 32'd400, 1'b1);
    send_poll(KIND_POLL, 6'h1F, 32'd420, 1'b1);
    // Two keys at once across the wrap of the time stamp.
    send_poll(KIND_POLL, 6'h19, 32'hFFFF_FFF0, 1'b0);
    send_poll(KIND_POLL, 6'h19, 32'h0000_0004, 1'b0);
    // A glitch restarts the timer; settling back to the accepted value does nothing.
    send_poll(KIND_POLL, 6'h18, 32'd10, 1'b1);
    send_poll(KIND_POLL, 6'h19, 32'd12, 1'b1);
    send_poll(KIND_POLL, 6'h19, 32'd40, 1'b1);
    send_poll(KIND_START, 6'h00, 32'hFFFF_FFFF, 1'b0);
    send_poll(KIND_POLL, 6'h00, 32'hFFFF_FFFF, 1'b1);
    send_poll(KIND_POLL, 6'h3F, 32'h8000_0000, 1'b1);
    send_poll(KIND_POLL, 6'h3F, 32'hFFFF_FFFF, 1'b1);
    drain_reports();
  endtask

  // Burst limit, table codes and debounce extremes.
  task automatic test_config_extremes();
    send_gap_max = GAP_MAX;
    recv_stall_max = GAP_MAX;
    write_all(1'b1, 16'd0, 8'd2, 10'h2AA);
    for (int i = 0; i < 8; i++) begin
      press_and_release(i % kdp_pkg::KEYS_W);
    end
    drain_reports();
    write_reg(kdp_pkg::CFG_BURST, kdp_pkg::CFG_DATA_W'(0));
    for (int i = 0; i < 4; i++) begin
      press_and_release(kdp_pkg::KEYS_W - 1 - i);
    end
    drain_reports();
    write_all(1'b1, 16'd1, 8'd255, 10'h3FF);
    for (int i = 0; i < 10; i++) begin
      press_and_release($urandom_range(0, kdp_pkg::KEYS_W - 1));
    end
    drain_reports();
    // Longest debounce, one short of it and exactly it, across the wrap.
    write_all(1'b1, 16'hFFFF, 8'd6, 10'h000);
    send_poll(KIND_POLL, 6'h3B, 32'hFFFF_8000, 1'b1);
    send_poll(KIND_POLL, 6'h3B, 32'h0000_7FFE, 1'b0);
    send_poll(KIND_POLL, 6'h3B, 32'h0000_7FFF, 1'b1);
    drain_reports();
    write_all(1'b1, 16'd20, 8'd6, 10'd585);
  endtask

  // With the block disabled nothing changes, starts included.
  task automatic test_disabled();
    send_gap_max = GAP_MAX;
    recv_stall_max = 0;
    write_reg(kdp_pkg::CFG_ENABLE, kdp_pkg::CFG_DATA_W'(0));
    repeat (30) random_noise();
    drain_reports();
    write_reg(kdp_pkg::CFG_ENABLE, kdp_pkg::CFG_DATA_W'(1));
  endtask

  // Receiver holds off while beats keep coming, so the input stalls.
  task automatic test_backpressure();
    int goal;
    send_gap_max = 0;
    recv_stall_max = 0;
    goal = items_sent + 40;
    hold_cycles = 80;
    while (items_sent < goal) begin
      debounce_sequence(next_target());
    end
    drain_reports();
  endtask

  // Phases of random settings and traffic with varying idle patterns.
  task automatic test_random_traffic();
    int goal;
    logic [kdp_pkg::DEB_W-1:0] deb;
    logic [kdp_pkg::LIMIT_W-1:0] lim;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 5))
        0: deb = '0;
        1: deb = '1;
        default: deb = kdp_pkg::DEB_W'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 4))
        0: lim = '0;
        1: lim = '1;
        default: lim = kdp_pkg::LIMIT_W'($urandom_range(1, 8));
      endcase
      write_all(1'b1, deb, lim, kdp_pkg::TABLE_W'($urandom_range(0, 1023)));
      clock_ms = ($urandom_range(0, 2) == 0) ? $urandom() : clock_ms;
      send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
      recv_stall_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
      goal = items_sent + 135;
      while (items_sent < goal) begin
        if ($urandom_range(0, 9) < 8) begin
          debounce_sequence(next_target());
        end else begin
          random_noise();
        end
      end
      drain_reports();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.kind = KIND_POLL;
    in_bus.port_sample = '1;
    in_bus.now_ms = '0;
    in_bus.irq_level_low = 1'b0;
    cfg_model.enable = 1'b1;
    cfg_model.debounce_ms = kdp_pkg::DEBOUNCE_RST;
    cfg_model.fast_burst_limit = kdp_pkg::LIMIT_RST;
    cfg_model.page_mode_table = kdp_pkg::TABLE_RST;
    p_last = kdp_pkg::PORT_IDLE;
    p_accepted = kdp_pkg::PORT_IDLE;
    p_change_time = '0;
    p_irq = 1'b0;
    p_page = '0;
    p_streak = '0;
    p_full = '0;
    p_partial = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_basics();
    test_config_extremes();
    test_disabled();
    test_backpressure();
    test_random_traffic();

    drain_reports();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
design/kdp_pkg.sv
design/kdp_if.sv
design/kdp_cfg.sv
design/kdp_in_stage.sv
design/kdp_policy.sv
design/key_debounce_page_refresh_policy_unit.sv
design/kdp_checker.sv
tb/sv/tb_top.sv
